// ===== hdl/mm64_pkg.sv =====
// Shared types and constants for the MurmurHash64A streaming engine.
// No dependencies; imported by every module of the block.
package mm64_pkg;

    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT  = 47;
    localparam logic [63:0] SEED_RESET = 64'd76493;
    localparam int          LEN_W      = 31;
    localparam int          NB_W       = 4;
    localparam logic [3:0]  NB_FULL    = 4'd8;

    localparam logic [1:0]  KIND_NONE  = 2'd0;
    localparam logic [1:0]  KIND_FULL  = 2'd1;
    localparam logic [1:0]  KIND_TAIL  = 2'd2;

    typedef struct packed {
        logic [63:0]      word;
        logic [NB_W-1:0]  nbytes;
        logic [1:0]       kind;
        logic             first;
        logic             last;
        logic [LEN_W-1:0] len;
    } mm64_item_t;

    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

// ===== hdl/murmur64a_hash.sv =====
// MurmurHash64A streaming engine. Each request is one little-endian 64-bit word;
// tuser marks the first word of a message (its msg_len seeds the accumulator) and
// tlast the final word, which returns the digest and a length-mismatch flag.
// Every 64x64 multiply runs on one shared 32x32 multiplier in the hash engine. A
// word costs a dispatch plus its multiplies: three for a full word, one for a tail
// word and none for an empty word, plus one more for a first word and one more and
// an output step for a last word. A 2-deep queue lets input keep arriving meanwhile.
// Write the seed register via cfg_valid/cfg_data only while idle; this is not enforced.
module murmur64a_hash #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // data_word[63:0], valid_bytes[67:64], msg_len[98:68]
    input  logic         s_tuser,   // is_first
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // digest[63:0]
    output logic         m_tuser,   // length_error
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data
);
    import mm64_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [63:0]      seed_reg;
    logic             f_valid;
    logic             f_ready;
    mm64_item_t       f_item;
    logic             q_valid;
    logic             q_ready;
    mm64_item_t       q_item;
    logic [CNT_W-1:0] q_level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    mm64_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    mm64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item),
        .level      (q_level)
    );

    mm64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_item  (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_item))
        else $error("front stage lost a request while the queue was full");

    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= CNT_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready && !(f_valid && f_ready) |=> q_level == $past(q_level) - CNT_W'(1))
        else $error("queue level did not follow a pop");
`endif

endmodule

// ===== hdl/mm64_front.sv =====
// Input stage: takes stream requests, saturates the byte count, masks tail bytes
// and classifies each word. Depends on mm64_pkg.
module mm64_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [103:0]         s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 item_valid,
    input  logic                 item_ready,
    output mm64_pkg::mm64_item_t item
);
    import mm64_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    mm64_item_t      item_reg;
    mm64_item_t      item_next;
    logic [NB_W-1:0] nb_raw;
    logic [NB_W-1:0] nb_sat;
    logic [63:0]     masked;
    logic            accept;

    assign s_tready   = !valid_reg || item_ready;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        nb_raw = s_tdata[67:64];
        nb_sat = (nb_raw > NB_FULL) ? NB_FULL : nb_raw;
        for (int b = 0; b < 8; b++)
        begin
            masked[b*8 +: 8] = (NB_W'(b) < nb_sat) ? s_tdata[b*8 +: 8] : 8'h00;
        end
        item_next.word   = masked;
        item_next.nbytes = nb_sat;
        if (nb_sat == NB_FULL)
        begin
            item_next.kind = KIND_FULL;
        end
        else if (nb_sat != '0)
        begin
            item_next.kind = KIND_TAIL;
        end
        else
        begin
            item_next.kind = KIND_NONE;
        end
        item_next.first = s_tuser;
        item_next.last  = s_tlast;
        item_next.len   = s_tdata[98:68];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hdl/mm64_queue.sv =====
// Small FIFO of classified words between the input stage and the hash engine.
// Depends on mm64_pkg.
module mm64_queue #(
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    output logic                         push_ready,
    input  mm64_pkg::mm64_item_t         push_item,
    output logic                         pop_valid,
    input  logic                         pop_ready,
    output mm64_pkg::mm64_item_t         pop_item,
    output logic [$clog2(DEPTH+1)-1:0]   level
);
    import mm64_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mm64_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign level      = count_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/mm64_back.sv =====
// Hash engine: sequences seeding, word mix, tail mix and finalization over one
// shared 32x32 multiplier, and holds the result register. Depends on mm64_pkg.
module mm64_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [63:0]          seed,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  mm64_pkg::mm64_item_t pop_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic                 m_tuser
);
    import mm64_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    localparam logic [2:0] PH_SEED  = 3'd0;
    localparam logic [2:0] PH_K1    = 3'd1;
    localparam logic [2:0] PH_K2    = 3'd2;
    localparam logic [2:0] PH_ACC   = 3'd3;
    localparam logic [2:0] PH_FIN   = 3'd4;

    localparam logic [1:0] STEP_LL  = 2'd0;
    localparam logic [1:0] STEP_LH  = 2'd1;
    localparam logic [1:0] STEP_HL  = 2'd2;

    typedef struct packed {
        logic [1:0]  state;
        logic [2:0]  phase;
        logic [63:0] a;
    } disp_t;

    logic [1:0]       state_reg,  state_next;
    logic [2:0]       phase_reg,  phase_next;
    logic [1:0]       step_reg,   step_next;
    logic [63:0]      a_reg,      a_next;
    logic [63:0]      prod_reg,   prod_next;
    logic [63:0]      acc_reg,    acc_next;
    logic [LEN_W-1:0] bytes_reg,  bytes_next;
    logic [LEN_W-1:0] exp_reg,    exp_next;
    mm64_item_t       cur_reg,    cur_next;
    logic             ovalid_reg, ovalid_next;
    logic [63:0]      odig_reg,   odig_next;
    logic             oerr_reg,   oerr_next;

    logic [31:0]      mul_x;
    logic [31:0]      mul_y;
    logic [63:0]      mul_p;
    logic [63:0]      prod_sum;
    logic [LEN_W:0]   bsum;
    logic [63:0]      seeded;
    disp_t            d;

    function automatic disp_t dispatch(input logic [63:0] acc, input mm64_item_t it);
        disp_t r;
        r.state = ST_IDLE;
        r.phase = PH_ACC;
        r.a     = acc;
        if (it.kind == KIND_FULL)
        begin
            r.state = ST_MUL;
            r.phase = PH_K1;
            r.a     = it.word;
        end
        else if (it.kind == KIND_TAIL)
        begin
            r.state = ST_MUL;
            r.phase = PH_ACC;
            r.a     = acc ^ it.word;
        end
        else if (it.last)
        begin
            r.state = ST_MUL;
            r.phase = PH_FIN;
            r.a     = xor_shift(acc);
        end
        return r;
    endfunction

    assign pop_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = odig_reg;
    assign m_tuser   = oerr_reg;

    assign mul_x    = (step_reg == STEP_HL) ? a_reg[63:32] : a_reg[31:0];
    assign mul_y    = (step_reg == STEP_LH) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    assign mul_p    = {32'h0, mul_x} * {32'h0, mul_y};
    assign prod_sum = prod_reg + {mul_p[31:0], 32'h0};
    assign seeded   = seed ^ prod_sum;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        a_next      = a_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        bytes_next  = bytes_reg;
        exp_next    = exp_reg;
        cur_next    = cur_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odig_next   = odig_reg;
        oerr_next   = oerr_reg;
        bsum        = {1'b0, bytes_reg} + (LEN_W + 1)'(pop_item.nbytes);
        d           = dispatch(acc_reg, pop_item);

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_next = pop_item;
                    step_next = STEP_LL;
                    if (pop_item.first)
                    begin
                        bytes_next = LEN_W'(pop_item.nbytes);
                        exp_next   = pop_item.len;
                        state_next = ST_MUL;
                        phase_next = PH_SEED;
                        a_next     = {33'h0, pop_item.len};
                    end
                    else
                    begin
                        bytes_next = bsum[LEN_W] ? {LEN_W{1'b1}} : bsum[LEN_W-1:0];
                        state_next = d.state;
                        phase_next = d.phase;
                        a_next     = d.a;
                    end
                end
            end
            ST_MUL:
            begin
                case (step_reg)
                    STEP_LL:
                    begin
                        prod_next = mul_p;
                        step_next = STEP_LH;
                    end
                    STEP_LH:
                    begin
                        prod_next = prod_sum;
                        step_next = STEP_HL;
                    end
                    default:
                    begin
                        step_next = STEP_LL;
                        case (phase_reg)
                            PH_SEED:
                            begin
                                acc_next = seeded;
                                d = dispatch(seeded, cur_reg);
                                state_next = d.state;
                                phase_next = d.phase;
                                a_next     = d.a;
                            end
                            PH_K1:
                            begin
                                a_next     = xor_shift(prod_sum);
                                phase_next = PH_K2;
                            end
                            PH_K2:
                            begin
                                a_next     = acc_reg ^ prod_sum;
                                phase_next = PH_ACC;
                            end
                            PH_ACC:
                            begin
                                acc_next = prod_sum;
                                if (cur_reg.last)
                                begin
                                    a_next     = xor_shift(prod_sum);
                                    phase_next = PH_FIN;
                                end
                                else
                                begin
                                    state_next = ST_IDLE;
                                end
                            end
                            PH_FIN:
                            begin
                                a_next     = xor_shift(prod_sum);
                                state_next = ST_OUT;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                endcase
            end
            ST_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odig_next   = a_reg;
                    oerr_next   = (bytes_reg != exp_reg);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_SEED;
            step_reg   <= STEP_LL;
            acc_reg    <= '0;
            bytes_reg  <= '0;
            exp_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            acc_reg    <= acc_next;
            bytes_reg  <= bytes_next;
            exp_reg    <= exp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
        cur_reg  <= cur_next;
        odig_reg <= odig_next;
        oerr_reg <= oerr_next;
    end

endmodule
